[rtl/splm_pkg.sv]
`timescale 1ns / 1ps

package splm_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_MARK    = 2'd1,
    OP_ACQUIRE = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_FREE      = 2'd0,
    PH_WRITING   = 2'd1,
    PH_READY     = 2'd2,
    PH_CONSUMING = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_INVALID   = 3'd2,
    ST_STALE     = 3'd3,
    ST_NOT_READY = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic load;    // latch request, issue table read
    logic commit;  // write back slot record, load result register
  } ctrl_cmd_t;

  localparam int GEN_W   = 32;
  localparam int IDX_W   = 4;
  localparam int LEN_W   = 16;
  localparam int CNT_W   = 5;
  localparam int STAT_W  = 3;

endpackage

[rtl/splm_ctrl.sv]
`timescale 1ns / 1ps

module splm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output splm_pkg::ctrl_cmd_t   cmd
);
  import splm_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // finish only once the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/splm_dpath.sv]
`timescale 1ns / 1ps

module splm_dpath #(
  parameter int MAX_SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  splm_pkg::ctrl_cmd_t           cmd,
  input  logic                          cfg_we,
  input  logic [splm_pkg::CNT_W-1:0]    cfg_active_slots,
  input  logic [1:0]                    in_op,
  input  logic [splm_pkg::IDX_W-1:0]    in_slot_index,
  input  logic [splm_pkg::GEN_W-1:0]    in_generation_in,
  input  logic [splm_pkg::GEN_W-1:0]    in_owner_seq,
  input  logic [splm_pkg::LEN_W-1:0]    in_length_in,
  output logic [splm_pkg::STAT_W-1:0]   out_status,
  output logic [splm_pkg::IDX_W-1:0]    out_slot_out,
  output logic [splm_pkg::GEN_W-1:0]    out_generation_out
);
  import splm_pkg::*;

  localparam int AW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW0   = $clog2(MAX_SLOTS + 1);
  localparam int CMPW  = (CW0 > CNT_W) ? CW0 : CNT_W;

  // slot state kept in flops (needed by the free search)
  phase_t              phase_r [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] held_r;
  logic [MAX_SLOTS-1:0] gen_vld_r;  // clear entry reads as generation one

  // slot record tables
  logic [GEN_W-1:0] gen_mem   [MAX_SLOTS];
  logic [GEN_W-1:0] owner_mem [MAX_SLOTS];
  logic [LEN_W-1:0] len_mem   [MAX_SLOTS];

  logic [CNT_W-1:0] active_r;

  // latched request
  op_t              req_op_r;
  logic [IDX_W-1:0] req_idx_r;
  logic [AW-1:0]    req_addr_r;
  logic [GEN_W-1:0] req_gen_r;
  logic [GEN_W-1:0] req_owner_r;
  logic [LEN_W-1:0] req_len_r;
  logic             req_found_r;
  logic [GEN_W-1:0] gen_rd_r;
  logic             gen_rd_vld_r;

  logic [STAT_W-1:0] out_status_r;
  logic [IDX_W-1:0]  out_slot_r;
  logic [GEN_W-1:0]  out_gen_r;

  logic [CMPW-1:0] count;
  logic            free_found;
  logic [AW-1:0]   free_slot;
  logic [AW-1:0]   rd_addr;

  logic [GEN_W-1:0] gen_cur;
  logic [GEN_W-1:0] gen_inc;
  phase_t           ph_cur;
  logic             idx_ok;
  status_t          status_c;
  logic             wr_gen, wr_owner, wr_len;
  logic [LEN_W-1:0] len_wdata;
  logic             ph_we;
  phase_t           ph_wdata;
  logic             held_we;
  logic             held_wdata;

  always_comb begin
    if (CMPW'(active_r) > CMPW'(MAX_SLOTS)) begin
      count = CMPW'(MAX_SLOTS);
    end else begin
      count = CMPW'(active_r);
    end
  end

  // lowest free slot below the active count
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if ((phase_r[i] == PH_FREE) && (CMPW'(i) < count)) begin
        free_found = 1'b1;
        free_slot  = AW'(i);
      end
    end
  end

  assign rd_addr = (op_t'(in_op) == OP_ALLOC) ? free_slot : AW'(in_slot_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= CNT_W'(16);
    end else if (cfg_we) begin
      active_r <= cfg_active_slots;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op_r     <= op_t'(in_op);
      req_idx_r    <= in_slot_index;
      req_addr_r   <= rd_addr;
      req_gen_r    <= in_generation_in;
      req_owner_r  <= in_owner_seq;
      req_len_r    <= in_length_in;
      req_found_r  <= free_found;
      gen_rd_r     <= gen_mem[rd_addr];
      gen_rd_vld_r <= gen_vld_r[rd_addr];
    end
  end

  assign gen_cur = gen_rd_vld_r ? gen_rd_r : GEN_W'(1);
  assign gen_inc = gen_cur + GEN_W'(1);
  assign ph_cur  = phase_r[req_addr_r];
  assign idx_ok  = CMPW'(req_idx_r) < count;

  always_comb begin
    status_c   = ST_OK;
    wr_gen     = 1'b0;
    wr_owner   = 1'b0;
    wr_len     = 1'b0;
    len_wdata  = req_len_r;
    ph_we      = 1'b0;
    ph_wdata   = PH_FREE;
    held_we    = 1'b0;
    held_wdata = 1'b0;
    if (req_op_r == OP_ALLOC) begin
      if (req_found_r) begin
        wr_gen     = 1'b1;
        wr_owner   = 1'b1;
        wr_len     = 1'b1;
        len_wdata  = '0;
        ph_we      = 1'b1;
        ph_wdata   = PH_WRITING;
        held_we    = 1'b1;
        held_wdata = 1'b1;
      end else begin
        status_c = ST_FULL;
      end
    end else if (!idx_ok) begin
      status_c = ST_INVALID;
    end else begin
      case (req_op_r)
        OP_MARK: begin
          if (ph_cur != PH_WRITING) begin
            status_c = ST_INVALID;
          end else begin
            wr_len   = 1'b1;
            ph_we    = 1'b1;
            ph_wdata = PH_READY;
          end
        end
        OP_ACQUIRE: begin
          if (gen_cur != req_gen_r) begin
            status_c = ST_STALE;
          end else if (ph_cur != PH_READY) begin
            status_c = ST_NOT_READY;
          end else begin
            ph_we    = 1'b1;
            ph_wdata = PH_CONSUMING;
          end
        end
        OP_RELEASE: begin
          if (gen_cur != req_gen_r) begin
            status_c = ST_STALE;
          end else begin
            ph_we      = 1'b1;
            ph_wdata   = PH_FREE;
            held_we    = 1'b1;
            held_wdata = 1'b0;
          end
        end
        default: begin
          status_c = ST_INVALID;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        phase_r[i] <= PH_FREE;
      end
      held_r    <= '0;
      gen_vld_r <= '0;
    end else if (cmd.commit) begin
      if (ph_we) begin
        phase_r[req_addr_r] <= ph_wdata;
      end
      if (held_we) begin
        held_r[req_addr_r] <= held_wdata;
      end
      if (wr_gen) begin
        gen_vld_r[req_addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (wr_gen) begin
        gen_mem[req_addr_r] <= gen_inc;
      end
      if (wr_owner) begin
        owner_mem[req_addr_r] <= req_owner_r;
      end
      if (wr_len) begin
        len_mem[req_addr_r] <= len_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= status_c;
      if (req_op_r == OP_ALLOC && req_found_r) begin
        out_slot_r <= IDX_W'(req_addr_r);
        out_gen_r  <= gen_inc;
      end else begin
        out_slot_r <= '0;
        out_gen_r  <= '0;
      end
    end
  end

  assign out_status         = out_status_r;
  assign out_slot_out       = out_slot_r;
  assign out_generation_out = out_gen_r;

endmodule

[rtl/slot_pool_lifecycle_manager_unit.sv]
`timescale 1ns / 1ps
// Each request is latched with its table read on the accept edge; the check,
//   write-back and result register load follow in the commit step.
// A new request is taken only after the previous one has committed (load, then
//   commit step); a result left waiting holds the next request in the commit step.
// Reset (rst_n low, synchronous): all slots free, generations read as 1,
//   active count 16, no result pending. No clearing pass needed.
module slot_pool_lifecycle_manager_unit #(
  parameter int MAX_SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [splm_pkg::CNT_W-1:0]    cfg_active_slots,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_op,
  input  logic [splm_pkg::IDX_W-1:0]    in_slot_index,
  input  logic [splm_pkg::GEN_W-1:0]    in_generation_in,
  input  logic [splm_pkg::GEN_W-1:0]    in_owner_seq,
  input  logic [splm_pkg::LEN_W-1:0]    in_length_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [splm_pkg::STAT_W-1:0]   out_status,
  output logic [splm_pkg::IDX_W-1:0]    out_slot_out,
  output logic [splm_pkg::GEN_W-1:0]    out_generation_out
);
  import splm_pkg::*;

  ctrl_cmd_t cmd;

  assign cfg_ready = 1'b1;

  splm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  splm_dpath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg_we             (cfg_valid & cfg_ready),
    .cfg_active_slots   (cfg_active_slots),
    .in_op              (in_op),
    .in_slot_index      (in_slot_index),
    .in_generation_in   (in_generation_in),
    .in_owner_seq       (in_owner_seq),
    .in_length_in       (in_length_in),
    .out_status         (out_status),
    .out_slot_out       (out_slot_out),
    .out_generation_out (out_generation_out)
  );

endmodule

[verif/slot_pool_lifecycle_manager_unit_test.sv]
`timescale 1ns / 1ps

module slot_pool_lifecycle_manager_unit_test;
  import splm_pkg::*;

  typedef struct packed {
    status_t     st;
    logic [3:0]  slot;
    logic [31:0] gen;
  } pool_result_t;

  typedef struct packed {
    logic        is_cfg;
    logic [4:0]  cfg;
    op_t         op;
    logic [3:0]  idx;
    logic [31:0] gen;
    logic [31:0] owner;
    logic [15:0] len;
    logic        typed;
    pool_result_t want;
  } pool_row_t;

  localparam int SLOTS = 16;
  localparam int HOLD_CYCLES = 300;
  localparam pool_result_t NO_RESULT = '{ST_OK, 4'd0, 32'd0};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_active_slots;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  logic [3:0]  in_slot_index;
  logic [31:0] in_generation_in;
  logic [31:0] in_owner_seq;
  logic [15:0] in_length_in;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [3:0]  out_slot_out;
  logic [31:0] out_generation_out;

  slot_pool_lifecycle_manager_unit #(.MAX_SLOTS(SLOTS)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_active_slots   (cfg_active_slots),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_slot_index      (in_slot_index),
    .in_generation_in   (in_generation_in),
    .in_owner_seq       (in_owner_seq),
    .in_length_in       (in_length_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_slot_out       (out_slot_out),
    .out_generation_out (out_generation_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the pool
  phase_t      pool_phase [SLOTS];
  logic [31:0] pool_gen   [SLOTS];
  logic        pool_held  [SLOTS];
  logic [31:0] pool_owner [SLOTS];
  logic [15:0] pool_len   [SLOTS];
  logic [4:0]  pool_active;

  pool_result_t pool_expect [$];
  pool_result_t want_res;
  pool_row_t    dir_tab [28];
  pool_row_t    cur_row;
  logic         cur_typed = 1'b0;

  int mismatches = 0;
  int reqs_taken = 0;
  int results_seen = 0;
  int stat_seen [5] = '{0, 0, 0, 0, 0};
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int hold_reqs = 0;
  int hold_done = 0;
  int hold_left = 0;

  int active_plan [8] = '{16, 1, 31, 0, 3, 16, 9, 17};
  int idle_plan   [4] = '{0, 63, 0, 37};
  int stall_plan  [4] = '{0, 0, 63, 37};

  function automatic int unsigned usable_slots();
    return (pool_active > SLOTS) ? SLOTS : pool_active;
  endfunction

  task automatic clear_pool();
    for (int i = 0; i < SLOTS; i++) begin
      pool_phase[i] = PH_FREE;
      pool_gen[i]   = 32'd1;
      pool_held[i]  = 1'b0;
      pool_owner[i] = 32'd0;
      pool_len[i]   = 16'd0;
    end
    pool_active = 5'd16;
  endtask

  // apply one request to the shadow pool, return its result
  function automatic pool_result_t pool_apply(op_t op, logic [3:0] idx, logic [31:0] g,
                                              logic [31:0] own, logic [15:0] len);
    pool_result_t r;
    int unsigned cnt;
    logic found;
    r = NO_RESULT;
    cnt = usable_slots();
    found = 1'b0;
    if (op == OP_ALLOC) begin
      r.st = ST_FULL;
      for (int i = 0; i < cnt; i++) begin
        if (!found && pool_phase[i] == PH_FREE) begin
          found = 1'b1;
          pool_phase[i] = PH_WRITING;
          pool_gen[i]   = pool_gen[i] + 32'd1;
          pool_held[i]  = 1'b1;
          pool_owner[i] = own;
          pool_len[i]   = 16'd0;
          r.st   = ST_OK;
          r.slot = i[3:0];
          r.gen  = pool_gen[i];
        end
      end
    end else if (idx >= cnt) begin
      r.st = ST_INVALID;
    end else if (op == OP_MARK) begin
      if (pool_phase[idx] != PH_WRITING) begin
        r.st = ST_INVALID;
      end else begin
        pool_len[idx]   = len;
        pool_phase[idx] = PH_READY;
      end
    end else if (op == OP_ACQUIRE) begin
      if (pool_gen[idx] != g) r.st = ST_STALE;
      else if (pool_phase[idx] != PH_READY) r.st = ST_NOT_READY;
      else pool_phase[idx] = PH_CONSUMING;
    end else begin
      if (pool_gen[idx] != g) begin
        r.st = ST_STALE;
      end else begin
        pool_held[idx]  = 1'b0;
        pool_phase[idx] = PH_FREE;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("[%0t] result %0d: %s got 0x%0h, want 0x%0h",
               $time, results_seen, what, got, want);
  endtask

  // mostly lifecycle-consistent requests against live slots, some noise
  task automatic pick_request(output pool_row_t row);
    int unsigned cnt;
    int unsigned roll;
    int unsigned tries;
    row = '0;
    cnt = usable_slots();
    roll = $urandom_range(99, 0);
    row.owner = $urandom;
    row.len   = 16'($urandom);
    row.gen   = $urandom;
    row.idx   = 4'($urandom);
    if (roll < 12 || cnt == 0) begin
      row.op = op_t'($urandom_range(3, 0));
      case ($urandom_range(3, 0))
        0: row.gen = pool_gen[row.idx];
        1: row.gen = pool_gen[row.idx] + 32'd1;
        2: row.gen = pool_gen[row.idx] - 32'd1;
        default: ;
      endcase
    end else if (roll < 40) begin
      row.op = OP_ALLOC;
    end else begin
      tries = 0;
      row.idx = 4'($urandom_range(cnt - 1, 0));
      while (pool_phase[row.idx] == PH_FREE && tries < 4) begin
        row.idx = 4'($urandom_range(cnt - 1, 0));
        tries++;
      end
      row.gen = pool_gen[row.idx];
      case (pool_phase[row.idx])
        PH_WRITING:   row.op = (roll < 88) ? OP_MARK : OP_RELEASE;
        PH_READY:     row.op = (roll < 80) ? OP_ACQUIRE : OP_RELEASE;
        PH_CONSUMING: row.op = (roll < 90) ? OP_RELEASE : OP_ACQUIRE;
        default:      row.op = (roll < 70) ? OP_ACQUIRE : OP_RELEASE;
      endcase
    end
  endtask

  // random rows are built only after the previous request hit the shadow pool
  task automatic send_request(input logic rnd, input pool_row_t row);
    pool_row_t r;
    @(negedge clk);
    while ($urandom_range(99, 0) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    r = row;
    if (rnd) pick_request(r);
    cur_row          = r;
    cur_typed        = r.typed;
    in_op            = r.op;
    in_slot_index    = r.idx;
    in_generation_in = r.gen;
    in_owner_seq     = r.owner;
    in_length_in     = r.len;
    in_valid         = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pool_expect.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_active(input logic [4:0] v);
    drain();
    cfg_active_slots = v;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (hold_reqs != hold_done) begin
      hold_done = hold_reqs;
      hold_left = HOLD_CYCLES;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(99, 0) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) pool_active = cfg_active_slots;
      if (in_valid && in_ready) begin
        want_res = pool_apply(op_t'(in_op), in_slot_index, in_generation_in,
                              in_owner_seq, in_length_in);
        if (cur_typed) want_res = cur_row.want;
        pool_expect.push_back(want_res);
        reqs_taken++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (pool_expect.size() == 0) begin
          report_mismatch("result with no request pending, status",
                          32'(out_status), 32'd0);
        end else begin
          want_res = pool_expect.pop_front();
          stat_seen[int'(want_res.st)]++;
          if (out_status !== want_res.st)
            report_mismatch("status", 32'(out_status), 32'(want_res.st));
          if (out_slot_out !== want_res.slot)
            report_mismatch("slot", 32'(out_slot_out), 32'(want_res.slot));
          if (out_generation_out !== want_res.gen)
            report_mismatch("generation", out_generation_out, want_res.gen);
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    cfg_valid        = 1'b0;
    cfg_active_slots = 5'd16;
    in_valid         = 1'b0;
    in_op            = OP_ALLOC;
    in_slot_index    = '0;
    in_generation_in = '0;
    in_owner_seq     = '0;
    in_length_in     = '0;
    cur_row          = '0;
    clear_pool();

    //        cfg   val    op          idx    gen           owner         len
    dir_tab = '{
      '{1'b0, 5'd0, OP_ACQUIRE, 4'd0,  32'd1,        32'd0,        16'd0,
        1'b1, '{ST_NOT_READY, 4'd0, 32'd0}},
      '{1'b0, 5'd0, OP_RELEASE, 4'd15, 32'd0,        32'd0,        16'd0,
        1'b1, '{ST_STALE, 4'd0, 32'd0}},
      '{1'b0, 5'd0, OP_MARK,    4'd3,  32'd1,        32'd0,        16'h1234,
        1'b1, '{ST_INVALID, 4'd0, 32'd0}},
      '{1'b0, 5'd0, OP_ALLOC,   4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'd0,
        1'b1, '{ST_OK, 4'd0, 32'd2}},
      '{1'b0, 5'd0, OP_ALLOC,   4'd0,  32'd0,        32'd0,        16'hFFFF,
        1'b1, '{ST_OK, 4'd1, 32'd2}},
      '{1'b0, 5'd0, OP_MARK,    4'd0,  32'd0,        32'd0,        16'hFFFF,
        1'b1, '{ST_OK, 4'd0, 32'd0}},
      '{1'b0, 5'd0, OP_ACQUIRE, 4'd0,  32'd1,        32'd0,        16'd0,
        1'b1, '{ST_STALE, 4'd0, 32'd0}},
      '{1'b0, 5'd0, OP_ACQUIRE, 4'd1,  32'd2,        32'd0,        16'd0,
        1'b1, '{ST_NOT_READY, 4'd0, 32'd0}},
      '{1'b0, 5'd0, OP_ACQUIRE, 4'd0,  32'd2,        32'd0,        16'd0,
        1'b1, '{ST_OK, 4'd0, 32'd0}},
      '{1'b0, 5'd0, OP_MARK,    4'd0,  32'd2,        32'd0,        16'd0,
        1'b1, '{ST_INVALID, 4'd0, 32'd0}},
      '{1'b0, 5'd0, OP_ACQUIRE, 4'd0,  32'd2,        32'd0,        16'd0,
        1'b0, NO_RESULT},
      '{1'b0, 5'd0, OP_RELEASE, 4'd0,  32'hFFFFFFFF, 32'd0,        16'd0,
        1'b1, '{ST_STALE, 4'd0, 32'd0}},
      '{1'b0, 5'd0, OP_RELEASE, 4'd0,  32'd2,        32'd0,        16'd0,
        1'b1, '{ST_OK, 4'd0, 32'd0}},
      '{1'b0, 5'd0, OP_ALLOC,   4'd0,  32'd0,        32'h5A5AA5A5, 16'd0,
        1'b1, '{ST_OK, 4'd0, 32'd3}},
      '{1'b0, 5'd0, OP_RELEASE, 4'd1,  32'd2,        32'd0,        16'd0,
        1'b0, NO_RESULT},
      // releasing a slot that is already free
      '{1'b0, 5'd0, OP_RELEASE, 4'd1,  32'd2,        32'd0,        16'd0,
        1'b0, NO_RESULT},
      '{1'b0, 5'd0, OP_ALLOC,   4'd0,  32'd0,        32'd1,        16'd0,
        1'b0, NO_RESULT},
      '{1'b0, 5'd0, OP_MARK,    4'd1,  32'd0,        32'd0,        16'h8001,
        1'b0, NO_RESULT},
      '{1'b0, 5'd0, OP_RELEASE, 4'd1,  32'd3,        32'd0,        16'd0,
        1'b0, NO_RESULT},
      '{1'b1, 5'd1, OP_ALLOC,   4'd0,  32'd0,        32'd0,        16'd0,
        1'b0, NO_RESULT},
      '{1'b0, 5'd0, OP_ALLOC,   4'd0,  32'd0,        32'd7,        16'd0,
        1'b1, '{ST_FULL, 4'd0, 32'd0}},
      '{1'b0, 5'd0, OP_RELEASE, 4'd1,  32'd3,        32'd0,        16'd0,
        1'b1, '{ST_INVALID, 4'd0, 32'd0}},
      // zero active slots: nothing usable
      '{1'b1, 5'd0, OP_ALLOC,   4'd0,  32'd0,        32'd0,        16'd0,
        1'b0, NO_RESULT},
      '{1'b0, 5'd0, OP_ALLOC,   4'd0,  32'd0,        32'd9,        16'd0,
        1'b1, '{ST_FULL, 4'd0, 32'd0}},
      '{1'b0, 5'd0, OP_ACQUIRE, 4'd0,  32'd3,        32'd0,        16'd0,
        1'b1, '{ST_INVALID, 4'd0, 32'd0}},
      // count above the pool size clamps to the full pool
      '{1'b1, 5'd31, OP_ALLOC,  4'd0,  32'd0,        32'd0,        16'd0,
        1'b0, NO_RESULT},
      '{1'b0, 5'd0, OP_RELEASE, 4'd15, 32'd1,        32'd0,        16'd0,
        1'b1, '{ST_OK, 4'd0, 32'd0}},
      '{1'b0, 5'd0, OP_ALLOC,   4'd0,  32'd0,        32'h80000000, 16'd0,
        1'b0, NO_RESULT}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) set_active(dir_tab[i].cfg);
      else send_request(1'b0, dir_tab[i]);
    end

    for (int blk = 0; blk < 8; blk++) begin
      set_active(active_plan[blk][4:0]);
      in_idle_pct   = idle_plan[blk % 4];
      out_stall_pct = stall_plan[blk % 4];
      repeat (110) send_request(1'b1, '0);
    end

    // back-pressure: receiver holds off while the sender keeps pushing
    set_active(5'd16);
    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_reqs++;
    repeat (48) send_request(1'b1, '0);

    drain();
    repeat (10) @(posedge clk);

    $display("Ran %0d requests, checked %0d results, eight pool sizes, four idle/stall mixes,",
             reqs_taken, results_seen);
    $display("one long output hold-off; ok %0d full %0d invalid %0d stale %0d not ready %0d.",
             stat_seen[0], stat_seen[1], stat_seen[2], stat_seen[3], stat_seen[4]);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
